>>> design/jmpq_pkg.sv
// Package for the job priority queue: widths, op and status codes, FSM states.
package jmpq_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned IdW   = 16;
  localparam int unsigned PrioW = 32;
  localparam int unsigned EntW  = IdW + PrioW;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_PEEK    = 2'd2,
    OP_CHANGE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT_RD,
    S_LAST_RD,
    S_SRCH,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_WB,
    S_OUT
  } state_e;

endpackage

>>> design/job_max_priority_queue.sv
// Top level of the job priority queue: binary max-heap held in one RAM.
//
// Input item on s_axis (op, job_id, priority_req); one result item per input
// on m_axis (top_id, status, count). The block works on one item at a time:
// s_axis_tready is high only while no item is in progress.
// The heap lives in a single-port RAM with registered read (one access per
// cycle), so the time an item takes is set by the number of RAM accesses.
// Rejected items (empty, full) go straight to the result; peek reads the
// root; insert sifts the new entry up level by level; extract reads the root
// and the last entry, then sifts down (fewer accesses where a node lacks two
// children); change priority scans the count entries for the ID, then sifts
// up or down; not found ends after the scan. With 64 entries the worst case
// is a full scan, then a six-level sift down. The next item can be taken in
// the cycle after the result is accepted. Reset clears the count and the
// control state; heap contents are undefined but never read before they are
// written. While m_axis_tready is low the result item holds and no new item
// is taken.
module job_max_priority_queue #(
  parameter int unsigned Capacity = jmpq_pkg::CapacityDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] op, [17:2] job_id, [49:18] priority_req, [55:50] zero
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] top_id, [17:16] status, [24:18] count, [31:25] zero
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned EW = jmpq_pkg::EntW;
  localparam int unsigned IW = jmpq_pkg::IdW;
  localparam int unsigned PW = jmpq_pkg::PrioW;

  // Heap positions are 1-based in CW+1 bits; RAM address is position - 1
  localparam int unsigned PosW = CW + 1;

  jmpq_pkg::state_e state_q, state_d;
  jmpq_pkg::op_e    op_q, op_d;
  logic [IW-1:0]    id_q, id_d;
  logic [PW-1:0]    pr_q, pr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [PosW-1:0]  pos_q, pos_d;     // current hole position
  logic [PosW-1:0]  scan_q, scan_d;   // search read pointer / right-child-read flag
  logic [PosW-1:0]  found_q, found_d;
  logic [EW-1:0]    cur_q, cur_d;     // entry being sifted
  logic [EW-1:0]    oth_q, oth_d;     // larger of sifted entry and its left child
  logic [PosW-1:0]  big_q, big_d;
  logic [IW-1:0]    top_q, top_d;
  jmpq_pkg::status_e st_q, st_d;

  logic             we;
  logic [AW-1:0]    addr;
  logic [EW-1:0]    wdata, rdata;

  jmpq_ram #(.Width(EW), .Depth(Capacity)) u_ram (
    .clk_i,
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] to_addr(input logic [PosW-1:0] p);
    logic [PosW-1:0] a;
    a = p - PosW'(1);
    return a[AW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] prio(input logic [EW-1:0] e);
    return $signed(e[EW-1:IW]);
  endfunction

  logic [PosW-1:0] cnt_ext;
  assign cnt_ext = PosW'(cnt_q);

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jmpq_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; id_q <= id_d; pr_q <= pr_d; pos_q <= pos_d;
    scan_q <= scan_d; found_q <= found_d; cur_q <= cur_d; oth_q <= oth_d;
    big_q <= big_d; top_q <= top_d; st_q <= st_d;
  end

  assign s_axis_tready = (state_q == jmpq_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == jmpq_pkg::S_OUT);
  assign m_axis_tdata  = {7'd0, 7'(cnt_q), st_q, top_q};

  // Sequencer: next state, datapath and RAM control
  always_comb begin
    state_d = state_q; op_d = op_q; id_d = id_q; pr_d = pr_q; cnt_d = cnt_q;
    pos_d = pos_q; scan_d = scan_q; found_d = found_q; cur_d = cur_q;
    oth_d = oth_q; big_d = big_q; top_d = top_q; st_d = st_q;
    we = 1'b0; addr = '0; wdata = cur_q;
    case (state_q)
      jmpq_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d  = jmpq_pkg::op_e'(s_axis_tdata[1:0]);
          id_d  = s_axis_tdata[17:2];
          pr_d  = s_axis_tdata[49:18];
          top_d = '0;
          st_d  = jmpq_pkg::ST_OK;
          cur_d = {s_axis_tdata[49:18], s_axis_tdata[17:2]};
          state_d = jmpq_pkg::S_OUT;
          case (jmpq_pkg::op_e'(s_axis_tdata[1:0]))
            jmpq_pkg::OP_INSERT: begin
              if (cnt_q == CW'(Capacity)) begin
                st_d = jmpq_pkg::ST_FULL;
              end else begin
                cnt_d = cnt_q + CW'(1);
                pos_d = cnt_ext + PosW'(1);
                state_d = jmpq_pkg::S_UP_RD;
              end
            end
            jmpq_pkg::OP_CHANGE: begin
              if (cnt_q == '0) begin
                st_d = jmpq_pkg::ST_EMPTY;
              end else begin
                scan_d  = PosW'(1);
                found_d = '0;
                addr    = '0;
                state_d = jmpq_pkg::S_SRCH;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                st_d = jmpq_pkg::ST_EMPTY;
              end else begin
                addr = '0;
                state_d = jmpq_pkg::S_ROOT_RD;
              end
            end
          endcase
        end
      end
      jmpq_pkg::S_ROOT_RD: begin
        top_d = rdata[IW-1:0];
        if (op_q == jmpq_pkg::OP_PEEK) begin
          state_d = jmpq_pkg::S_OUT;
        end else begin
          addr = to_addr(cnt_ext);
          state_d = jmpq_pkg::S_LAST_RD;
        end
      end
      jmpq_pkg::S_LAST_RD: begin
        cur_d = rdata;
        cnt_d = cnt_q - CW'(1);
        pos_d = PosW'(1);
        state_d = jmpq_pkg::S_DN_RDL;
      end
      jmpq_pkg::S_SRCH: begin
        // rdata holds the entry at scan_q
        if (rdata[IW-1:0] == id_q) begin
          found_d = scan_q;
          cur_d   = rdata;
        end
        if (scan_q == cnt_ext) begin
          if (rdata[IW-1:0] != id_q && found_q == '0) begin
            st_d = jmpq_pkg::ST_NOTFOUND;
            state_d = jmpq_pkg::S_OUT;
          end else begin
            pos_d = (rdata[IW-1:0] == id_q) ? scan_q : found_q;
            cur_d = {pr_q, id_q};
            state_d = ($signed(pr_q) <
                      prio((rdata[IW-1:0] == id_q) ? rdata : cur_q))
                      ? jmpq_pkg::S_DN_RDL : jmpq_pkg::S_UP_RD;
          end
        end else begin
          scan_d = scan_q + PosW'(1);
          addr = to_addr(scan_q + PosW'(1));
        end
      end
      jmpq_pkg::S_UP_RD: begin
        if (pos_q == PosW'(1)) begin
          state_d = jmpq_pkg::S_WB;
        end else begin
          addr = to_addr(pos_q >> 1);
          state_d = jmpq_pkg::S_UP_CMP;
        end
      end
      jmpq_pkg::S_UP_CMP: begin
        if (prio(rdata) < prio(cur_q)) begin
          // move parent down into the hole
          we = 1'b1; addr = to_addr(pos_q); wdata = rdata;
          pos_d = pos_q >> 1;
          state_d = jmpq_pkg::S_UP_RD;
        end else begin
          state_d = jmpq_pkg::S_WB;
        end
      end
      jmpq_pkg::S_DN_RDL: begin
        oth_d = cur_q;
        big_d = pos_q;
        if ((pos_q << 1) <= cnt_ext) begin
          addr = to_addr(pos_q << 1);
          state_d = jmpq_pkg::S_DN_RDR;
        end else begin
          state_d = jmpq_pkg::S_WB;
        end
      end
      jmpq_pkg::S_DN_RDR: begin
        if (prio(rdata) > prio(cur_q)) begin
          oth_d = rdata; big_d = pos_q << 1;
        end
        if (((pos_q << 1) | PosW'(1)) <= cnt_ext) begin
          addr = to_addr((pos_q << 1) | PosW'(1));
          state_d = jmpq_pkg::S_DN_CMP;
        end else begin
          state_d = (prio(rdata) > prio(cur_q)) ? jmpq_pkg::S_DN_CMP
                                                : jmpq_pkg::S_WB;
          scan_d = '0;  // mark: no right child read
        end
        if (((pos_q << 1) | PosW'(1)) <= cnt_ext) scan_d = PosW'(1);
      end
      jmpq_pkg::S_DN_CMP: begin
        if (scan_q != '0 && prio(rdata) > prio(oth_q)) begin
          we = 1'b1; addr = to_addr(pos_q); wdata = rdata;
          pos_d = (pos_q << 1) | PosW'(1);
          state_d = jmpq_pkg::S_DN_RDL;
        end else if (big_q != pos_q) begin
          we = 1'b1; addr = to_addr(pos_q); wdata = oth_q;
          pos_d = big_q;
          state_d = jmpq_pkg::S_DN_RDL;
        end else begin
          state_d = jmpq_pkg::S_WB;
        end
      end
      jmpq_pkg::S_WB: begin
        we = 1'b1; addr = to_addr(pos_q); wdata = cur_q;
        state_d = jmpq_pkg::S_OUT;
      end
      jmpq_pkg::S_OUT: begin
        if (m_axis_tready) state_d = jmpq_pkg::S_IDLE;
      end
      default: state_d = jmpq_pkg::S_IDLE;
    endcase
  end

endmodule

>>> design/jmpq_ram.sv
// Generic single-port RAM with registered read.
module jmpq_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

>>> design/jmpq_checker.sv
// Port-level checker for the job priority queue, bound to the top level.
module jmpq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Never take an item while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // Drop ready right after an item is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready again right after an item");

  // A result that is not ok carries no top ID
  a_topz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17:16] != 2'd0 |-> m_axis_tdata[15:0] == 16'd0)
    else $error("top_id nonzero on error status");

  // Count never exceeds capacity
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[24:18] <= 7'(jmpq_pkg::CapacityDef))
    else $error("count above capacity");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind job_max_priority_queue jmpq_checker u_jmpq_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

>>> verif/testbench.sv
// Testbench for the job priority queue: heap predictor, directed and random stream traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cap = 64;
  localparam int DrainWait = 200;
  localparam int IdleLimit = 5000;

  typedef struct packed {
    logic [15:0]       top_id;
    jmpq_pkg::status_e status;
    logic [6:0]        count;
  } qres_t;

  // Predict the heap and compare results in order
  class heap_scoreboard;
    logic [15:0]        ids[Cap+1];
    logic signed [31:0] prios[Cap+1];
    int                 njobs;
    qres_t              pending[$];
    int                 errors;

    function void swap_at(int a, int b);
      logic [15:0] ti;
      logic signed [31:0] tp;
      ti = ids[a]; ids[a] = ids[b]; ids[b] = ti;
      tp = prios[a]; prios[a] = prios[b]; prios[b] = tp;
    endfunction

    function void raise(int p);
      while (p > 1 && prios[p/2] < prios[p]) begin
        swap_at(p/2, p);
        p = p / 2;
      end
    endfunction

    function void lower(int p);
      int l, r, big;
      forever begin
        l = 2 * p; r = l + 1; big = p;
        if (l <= njobs && prios[l] > prios[big]) big = l;
        if (r <= njobs && prios[r] > prios[big]) big = r;
        if (big == p) break;
        swap_at(p, big);
        p = big;
      end
    endfunction

    // Note an accepted input item and queue its result
    function void note_input(jmpq_pkg::op_e op, logic [15:0] id, logic signed [31:0] pr);
      qres_t e;
      int pos;
      logic signed [31:0] old;
      e.top_id = '0;
      e.status = jmpq_pkg::ST_OK;
      case (op)
        jmpq_pkg::OP_INSERT: begin
          if (njobs >= Cap) e.status = jmpq_pkg::ST_FULL;
          else begin
            njobs++;
            ids[njobs] = id; prios[njobs] = pr;
            raise(njobs);
          end
        end
        jmpq_pkg::OP_EXTRACT: begin
          if (njobs == 0) e.status = jmpq_pkg::ST_EMPTY;
          else begin
            e.top_id = ids[1];
            ids[1] = ids[njobs]; prios[1] = prios[njobs];
            njobs--;
            lower(1);
          end
        end
        jmpq_pkg::OP_PEEK: begin
          if (njobs == 0) e.status = jmpq_pkg::ST_EMPTY;
          else e.top_id = ids[1];
        end
        default: begin
          if (njobs == 0) e.status = jmpq_pkg::ST_EMPTY;
          else begin
            pos = 0;
            for (int i = 1; i <= njobs; i++) if (ids[i] == id) pos = i;
            if (pos == 0) e.status = jmpq_pkg::ST_NOTFOUND;
            else begin
              old = prios[pos];
              prios[pos] = pr;
              if (pr < old) lower(pos);
              else raise(pos);
            end
          end
        end
      endcase
      e.count = 7'(njobs);
      pending.push_back(e);
    endfunction

    // Check one result item against the oldest expectation
    function void check_result(logic [31:0] d);
      qres_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.top_id) begin
        $error("top_id: expected %0d, got %0d", e.top_id, d[15:0]); errors++;
      end
      if (d[17:16] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, d[17:16]); errors++;
      end
      if (d[24:18] !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, d[24:18]); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  heap_scoreboard sb = new();
  int idle_cycles = 0;
  logic [15:0] live_ids[$];

  job_max_priority_queue DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch for a stall with nothing accepted
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Check results at each accepting edge
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  // Drive ready with random stalls per result
  initial begin
    int waits;
    @(posedge rst_ni);
    forever begin
      waits = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) waits = 0;
      if (waits > 0) begin
        m_axis_tready <= 1'b0;
        repeat (waits) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Send one item, after a random gap when gaps is set; valid stays high until the next gap
  task automatic send_job(jmpq_pkg::op_e op, logic [15:0] id, logic signed [31:0] pr,
                          bit gaps);
    int waits;
    waits = gaps ? $urandom_range(0, 5) : 0;
    if (waits > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (waits) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, pr, id, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, id, pr);
    if (op == jmpq_pkg::OP_INSERT && sb.pending[$].status == jmpq_pkg::ST_OK)
      live_ids.push_back(id);
  endtask

  // Pick a priority biased toward extremes and ties
  function automatic logic signed [31:0] pick_prio();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(0, 7)) - 32'sd4;
      default: return $signed($urandom);
    endcase
  endfunction

  initial begin
    jmpq_pkg::op_e op;
    logic [15:0] id;
    bit gaps;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty cases, extremes, ties, change up/down/same/not found
    send_job(jmpq_pkg::OP_EXTRACT, 16'd0, 32'sd0, 1'b1);
    send_job(jmpq_pkg::OP_PEEK, 16'd0, 32'sd0, 1'b1);
    send_job(jmpq_pkg::OP_CHANGE, 16'd5, 32'sd1, 1'b1);
    send_job(jmpq_pkg::OP_INSERT, 16'hFFFF, 32'sh80000000, 1'b1);
    send_job(jmpq_pkg::OP_INSERT, 16'h0000, 32'sh7FFFFFFF, 1'b1);
    send_job(jmpq_pkg::OP_INSERT, 16'h1234, 32'sd10, 1'b1);
    send_job(jmpq_pkg::OP_INSERT, 16'h1235, 32'sd10, 1'b1);
    send_job(jmpq_pkg::OP_INSERT, 16'h1234, 32'sd3, 1'b1);
    send_job(jmpq_pkg::OP_PEEK, 16'd0, 32'sd0, 1'b1);
    send_job(jmpq_pkg::OP_CHANGE, 16'h7777, 32'sd0, 1'b1);
    send_job(jmpq_pkg::OP_CHANGE, 16'h1234, 32'sd3, 1'b1);
    send_job(jmpq_pkg::OP_CHANGE, 16'h1234, 32'sh7FFFFFFF, 1'b1);
    send_job(jmpq_pkg::OP_CHANGE, 16'h0000, 32'sh80000000, 1'b1);
    send_job(jmpq_pkg::OP_EXTRACT, 16'd0, 32'sd0, 1'b1);
    send_job(jmpq_pkg::OP_EXTRACT, 16'd0, 32'sd0, 1'b1);
    // Fill to capacity, then overflow, then a change while full
    while (sb.njobs < Cap)
      send_job(jmpq_pkg::OP_INSERT, 16'($urandom), pick_prio(), 1'b0);
    send_job(jmpq_pkg::OP_INSERT, 16'hAAAA, 32'sd1, 1'b1);
    send_job(jmpq_pkg::OP_CHANGE, live_ids[0], 32'sd0, 1'b1);
    // Hold off until all results are back
    s_axis_tvalid <= 1'b0;
    wait (sb.pending.size() == 0);
    // Random phase: drain and refill in waves
    for (int n = 0; n < 320; n++) begin
      gaps = ($urandom_range(0, 9) > 2);
      case ($urandom_range(0, 9))
        0, 1, 2: op = (n % 160 < 80) ? jmpq_pkg::OP_INSERT : jmpq_pkg::OP_EXTRACT;
        3, 4:    op = jmpq_pkg::OP_INSERT;
        5, 6:    op = jmpq_pkg::OP_EXTRACT;
        7:       op = jmpq_pkg::OP_PEEK;
        default: op = jmpq_pkg::OP_CHANGE;
      endcase
      if (op == jmpq_pkg::OP_CHANGE && live_ids.size() > 0 && $urandom_range(0, 3) != 0)
        id = live_ids[$urandom_range(0, live_ids.size() - 1)];
      else if ($urandom_range(0, 3) == 0)
        id = 16'($urandom_range(0, 7));
      else
        id = 16'($urandom);
      send_job(op, id, pick_prio(), gaps);
    end
    s_axis_tvalid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

>>> sim.f
design/jmpq_pkg.sv
design/jmpq_ram.sv
design/job_max_priority_queue.sv
design/jmpq_checker.sv
verif/testbench.sv
